FILE: src/pec_pkg.sv
`default_nettype none
package pec_pkg;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEL, ST_EDGE, ST_ADV, ST_B, ST_DOT1, ST_DOT2, ST_DOT3, ST_SWAP,
    ST_R, ST_NUM1, ST_NUM2, ST_NUM3, ST_DEN1, ST_DEN2, ST_DEN3, ST_NORM, ST_TSEL,
    ST_DIV, ST_PT1, ST_PT2, ST_PT3, ST_IN0, ST_IN1, ST_IN2, ST_IN3, ST_IN4, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MS_DX_BX, MS_DY_BY, MS_RY_BX, MS_RX_BY, MS_DX_BY, MS_DY_BX, MS_DX_T, MS_DY_T
  } mul_sel_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

  localparam logic CMD_INTERIOR = 1'b0;
  localparam logic CMD_BORDER   = 1'b1;

  localparam logic [1:0] CODE_NONE  = 2'd0;
  localparam logic [1:0] CODE_END   = 2'd1;
  localparam logic [1:0] CODE_START = 2'd2;
  localparam logic [1:0] CODE_BOTH  = 2'd3;

  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_C0X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C0Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C1X = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C1Y = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C2X = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C2Y = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_C3X = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_C3Y = 4'd7;

  typedef struct packed {
    logic     load_in;
    logic     border_sel;
    logic     clip_set;
    logic     code_clear;
    logic     edge_inc;
    logic     ld_b;
    logic     b_test;
    logic     ld_d;
    logic     swap;
    logic     ld_r_base;
    logic     ld_r_pt;
    logic     num_ld;
    logic     den_ld;
    logic     norm;
    logic     t_sel;
    logic     div_step;
    logic     pt_x;
    logic     pt_y;
    logic     tidx_clr;
    logic     mask_bit;
    logic     publish;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
  } ctl_cmd_t;

  typedef struct packed {
    logic cmd_border;
    logic border_ok;
    logic any_both_out;
    logic cross_bit;
    logic both_out_bit;
    logic diff_bit;
    logic code_both;
    logic need_div;
    logic div_last;
    logic tidx_last;
    logic edge_last;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: src/pec_ctrl.sv
`default_nettype none
module pec_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire pec_pkg::dp_stat_t stat,
  output pec_pkg::ctl_cmd_t      cmd
);

  pec_pkg::state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pec_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != pec_pkg::ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = pec_pkg::MS_DX_BX;
    cmd.acc_op  = pec_pkg::ACC_HOLD;
    case (state)
      pec_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = pec_pkg::ST_SEL;
        end
      end
      pec_pkg::ST_SEL: begin
        if (stat.cmd_border) begin
          if (stat.border_ok) begin
            cmd.border_sel = 1'b1;
            state_next     = pec_pkg::ST_B;
          end else begin
            state_next = pec_pkg::ST_FIN;
          end
        end else if (stat.any_both_out) begin
          state_next = pec_pkg::ST_FIN;
        end else begin
          state_next = pec_pkg::ST_EDGE;
        end
      end
      pec_pkg::ST_EDGE: begin
        if (!stat.cross_bit) begin
          state_next = pec_pkg::ST_ADV;
        end else if (!stat.code_both && stat.both_out_bit) begin
          cmd.code_clear = 1'b1;
          state_next     = pec_pkg::ST_FIN;
        end else if (stat.diff_bit) begin
          cmd.clip_set = 1'b1;
          state_next   = pec_pkg::ST_B;
        end else begin
          state_next = pec_pkg::ST_ADV;
        end
      end
      pec_pkg::ST_ADV: begin
        if (stat.edge_last) begin
          state_next = pec_pkg::ST_FIN;
        end else begin
          cmd.edge_inc = 1'b1;
          state_next   = pec_pkg::ST_EDGE;
        end
      end
      pec_pkg::ST_B: begin
        cmd.ld_b   = 1'b1;
        cmd.ld_d   = 1'b1;
        state_next = pec_pkg::ST_DOT1;
      end
      pec_pkg::ST_DOT1: begin
        cmd.mul_sel = pec_pkg::MS_DX_BX;
        state_next  = pec_pkg::ST_DOT2;
      end
      pec_pkg::ST_DOT2: begin
        cmd.acc_op  = pec_pkg::ACC_LOAD;
        cmd.mul_sel = pec_pkg::MS_DY_BY;
        state_next  = pec_pkg::ST_DOT3;
      end
      pec_pkg::ST_DOT3: begin
        cmd.acc_op = pec_pkg::ACC_ADD;
        state_next = pec_pkg::ST_SWAP;
      end
      pec_pkg::ST_SWAP: begin
        cmd.swap   = 1'b1;
        state_next = pec_pkg::ST_R;
      end
      pec_pkg::ST_R: begin
        cmd.ld_r_base = 1'b1;
        state_next    = pec_pkg::ST_NUM1;
      end
      pec_pkg::ST_NUM1: begin
        cmd.mul_sel = pec_pkg::MS_RY_BX;
        state_next  = pec_pkg::ST_NUM2;
      end
      pec_pkg::ST_NUM2: begin
        cmd.acc_op  = pec_pkg::ACC_LOAD;
        cmd.mul_sel = pec_pkg::MS_RX_BY;
        state_next  = pec_pkg::ST_NUM3;
      end
      pec_pkg::ST_NUM3: begin
        cmd.acc_op  = pec_pkg::ACC_SUB;
        cmd.mul_sel = pec_pkg::MS_DX_BY;
        state_next  = pec_pkg::ST_DEN1;
      end
      pec_pkg::ST_DEN1: begin
        cmd.num_ld  = 1'b1;
        cmd.acc_op  = pec_pkg::ACC_LOAD;
        cmd.mul_sel = pec_pkg::MS_DY_BX;
        state_next  = pec_pkg::ST_DEN2;
      end
      pec_pkg::ST_DEN2: begin
        cmd.acc_op = pec_pkg::ACC_SUB;
        state_next = pec_pkg::ST_DEN3;
      end
      pec_pkg::ST_DEN3: begin
        cmd.den_ld = 1'b1;
        state_next = pec_pkg::ST_NORM;
      end
      pec_pkg::ST_NORM: begin
        cmd.norm   = 1'b1;
        state_next = pec_pkg::ST_TSEL;
      end
      pec_pkg::ST_TSEL: begin
        cmd.t_sel  = 1'b1;
        state_next = stat.need_div ? pec_pkg::ST_DIV : pec_pkg::ST_PT1;
      end
      pec_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = pec_pkg::ST_PT1;
        end
      end
      pec_pkg::ST_PT1: begin
        cmd.mul_sel = pec_pkg::MS_DX_T;
        state_next  = pec_pkg::ST_PT2;
      end
      pec_pkg::ST_PT2: begin
        cmd.pt_x    = 1'b1;
        cmd.mul_sel = pec_pkg::MS_DY_T;
        state_next  = pec_pkg::ST_PT3;
      end
      pec_pkg::ST_PT3: begin
        cmd.pt_y = 1'b1;
        if (stat.cmd_border) begin
          state_next = pec_pkg::ST_FIN;
        end else begin
          cmd.tidx_clr = 1'b1;
          state_next   = pec_pkg::ST_IN0;
        end
      end
      pec_pkg::ST_IN0: begin
        cmd.ld_b    = 1'b1;
        cmd.b_test  = 1'b1;
        cmd.ld_r_pt = 1'b1;
        state_next  = pec_pkg::ST_IN1;
      end
      pec_pkg::ST_IN1: begin
        cmd.mul_sel = pec_pkg::MS_RY_BX;
        state_next  = pec_pkg::ST_IN2;
      end
      pec_pkg::ST_IN2: begin
        cmd.acc_op  = pec_pkg::ACC_LOAD;
        cmd.mul_sel = pec_pkg::MS_RX_BY;
        state_next  = pec_pkg::ST_IN3;
      end
      pec_pkg::ST_IN3: begin
        cmd.acc_op = pec_pkg::ACC_SUB;
        state_next = pec_pkg::ST_IN4;
      end
      pec_pkg::ST_IN4: begin
        cmd.mask_bit = 1'b1;
        state_next   = stat.tidx_last ? pec_pkg::ST_ADV : pec_pkg::ST_IN0;
      end
      pec_pkg::ST_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.publish = 1'b1;
          state_next  = pec_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pec_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
`default_nettype wire

FILE: src/pec_dp.sv
`default_nettype none
module pec_dp #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [pec_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic signed [COORD_WIDTH-1:0]        cfg_data,
  input  wire logic                                 in_cmd,
  input  wire logic signed [COORD_WIDTH-1:0]        in_start_x,
  input  wire logic signed [COORD_WIDTH-1:0]        in_start_y,
  input  wire logic signed [COORD_WIDTH-1:0]        in_end_x,
  input  wire logic signed [COORD_WIDTH-1:0]        in_end_y,
  input  wire logic [3:0]                           in_start_inside,
  input  wire logic [3:0]                           in_end_inside,
  input  wire pec_pkg::ctl_cmd_t                    cmd,
  output pec_pkg::dp_stat_t                         stat,
  output logic [1:0]                                clip_code,
  output logic signed [COORD_WIDTH-1:0]             clip_start_x,
  output logic signed [COORD_WIDTH-1:0]             clip_start_y,
  output logic signed [COORD_WIDTH-1:0]             clip_end_x,
  output logic signed [COORD_WIDTH-1:0]             clip_end_y
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned OPW  = (W + 1 > FRAC_BITS + 2) ? W + 1 : FRAC_BITS + 2;
  localparam int unsigned PW   = 2 * OPW;
  localparam int unsigned ACCW = 2 * W + 4;
  localparam int unsigned TW   = FRAC_BITS + 1;
  localparam int unsigned CNTW = $clog2(FRAC_BITS);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(FRAC_BITS - 1);
  localparam logic [TW-1:0] T_ONE  = TW'(1) << FRAC_BITS;
  localparam logic [TW-1:0] T_HALF = TW'(1) << (FRAC_BITS - 1);

  logic signed [W-1:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;

  logic               cmd_r;
  logic signed [W-1:0] sx, sy, ex, ey, basex, basey;
  logic [3:0]         ms, me, crossing;
  logic [1:0]         code, eidx, tidx;
  logic               clip_end;
  logic signed [DW-1:0] bx, by, dx, dy, rx, ry;
  logic signed [PW-1:0] p;
  logic signed [ACCW-1:0] acc, num, den;
  logic [TW-1:0]      t;
  logic [CNTW-1:0]    dcnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      c0x <= '0; c0y <= '0; c1x <= '0; c1y <= '0;
      c2x <= '0; c2y <= '0; c3x <= '0; c3y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pec_pkg::REG_C0X: c0x <= cfg_data;
        pec_pkg::REG_C0Y: c0y <= cfg_data;
        pec_pkg::REG_C1X: c1x <= cfg_data;
        pec_pkg::REG_C1Y: c1y <= cfg_data;
        pec_pkg::REG_C2X: c2x <= cfg_data;
        pec_pkg::REG_C2Y: c2y <= cfg_data;
        pec_pkg::REG_C3X: c3x <= cfg_data;
        pec_pkg::REG_C3Y: c3y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [1:0] cidx, cidx1;
  logic signed [W-1:0] cax, cay, cbx, cby;

  assign cidx  = (cmd.b_test || cmd.ld_r_pt) ? tidx : eidx;
  assign cidx1 = cidx + 2'd1;

  always_comb begin
    case (cidx)
      2'd0: begin cax = c0x; cay = c0y; end
      2'd1: begin cax = c1x; cay = c1y; end
      2'd2: begin cax = c2x; cay = c2y; end
      default: begin cax = c3x; cay = c3y; end
    endcase
    case (cidx1)
      2'd0: begin cbx = c0x; cby = c0y; end
      2'd1: begin cbx = c1x; cby = c1y; end
      2'd2: begin cbx = c2x; cby = c2y; end
      default: begin cbx = c3x; cby = c3y; end
    endcase
  end

  logic signed [OPW-1:0] ma, mb, t_op;
  assign t_op = OPW'($signed({1'b0, t}));

  always_comb begin
    case (cmd.mul_sel)
      pec_pkg::MS_DX_BX: begin ma = OPW'(dx); mb = OPW'(bx); end
      pec_pkg::MS_DY_BY: begin ma = OPW'(dy); mb = OPW'(by); end
      pec_pkg::MS_RY_BX: begin ma = OPW'(ry); mb = OPW'(bx); end
      pec_pkg::MS_RX_BY: begin ma = OPW'(rx); mb = OPW'(by); end
      pec_pkg::MS_DX_BY: begin ma = OPW'(dx); mb = OPW'(by); end
      pec_pkg::MS_DY_BX: begin ma = OPW'(dy); mb = OPW'(bx); end
      pec_pkg::MS_DX_T:  begin ma = OPW'(dx); mb = t_op; end
      pec_pkg::MS_DY_T:  begin ma = OPW'(dy); mb = t_op; end
      default:           begin ma = OPW'(dx); mb = OPW'(bx); end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
  end

  logic signed [ACCW-1:0] p_acc;
  assign p_acc = ACCW'(p);

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      pec_pkg::ACC_LOAD: acc <= p_acc;
      pec_pkg::ACC_ADD:  acc <= acc + p_acc;
      pec_pkg::ACC_SUB:  acc <= acc - p_acc;
      default: ;
    endcase
  end

  // border mode decode
  logic [3:0] bx_mask, b_all;
  logic       b_onehot;
  logic [1:0] b_edge;
  assign bx_mask  = ms ^ me;
  assign b_all    = ms & me;
  assign b_onehot = (bx_mask != 4'd0) && ((bx_mask & (bx_mask - 4'd1)) == 4'd0);
  always_comb begin
    case (bx_mask)
      4'b0010: b_edge = 2'd1;
      4'b0100: b_edge = 2'd2;
      4'b1000: b_edge = 2'd3;
      default: b_edge = 2'd0;
    endcase
  end

  logic [ACCW-1:0] nshift;
  logic signed [W-1:0] p_sh_lo, newc;
  logic signed [PW-1:0] p_sh;
  assign nshift  = {num[ACCW-2:0], 1'b0};
  assign p_sh    = p >>> FRAC_BITS;
  assign p_sh_lo = p_sh[W-1:0];

  always_comb begin
    if (cmd.pt_x) begin
      newc = basex + p_sh_lo;
    end else begin
      newc = basey + p_sh_lo;
    end
  end

  logic signed [W-1:0] ptx, pty;
  assign ptx = clip_end ? ex : sx;
  assign pty = clip_end ? ey : sy;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r    <= in_cmd;
      sx       <= in_start_x;
      sy       <= in_start_y;
      ex       <= in_end_x;
      ey       <= in_end_y;
      ms       <= in_start_inside;
      me       <= in_end_inside;
      crossing <= in_start_inside ^ in_end_inside;
      code     <= pec_pkg::CODE_NONE;
      eidx     <= 2'd0;
    end
    if (cmd.border_sel) begin
      eidx     <= b_edge;
      clip_end <= |(ms & bx_mask);
      code     <= (|(ms & bx_mask)) ? pec_pkg::CODE_END : pec_pkg::CODE_START;
    end
    if (cmd.clip_set) begin
      clip_end <= ms[eidx];
      code     <= code | (ms[eidx] ? pec_pkg::CODE_END : pec_pkg::CODE_START);
    end
    if (cmd.code_clear) begin
      code <= pec_pkg::CODE_NONE;
    end
    if (cmd.edge_inc) begin
      eidx <= eidx + 2'd1;
    end
    if (cmd.ld_b) begin
      bx <= DW'(cbx) - DW'(cax);
      by <= DW'(cby) - DW'(cay);
    end
    if (cmd.ld_d) begin
      dx    <= DW'(ex) - DW'(sx);
      dy    <= DW'(ey) - DW'(sy);
      basex <= sx;
      basey <= sy;
    end
    if (cmd.swap && acc[ACCW-1]) begin
      basex <= ex;
      basey <= ey;
      dx    <= -dx;
      dy    <= -dy;
    end
    if (cmd.ld_r_base) begin
      rx <= DW'(basex) - DW'(cax);
      ry <= DW'(basey) - DW'(cay);
    end
    if (cmd.ld_r_pt) begin
      rx <= DW'(ptx) - DW'(cax);
      ry <= DW'(pty) - DW'(cay);
    end
    if (cmd.num_ld) begin
      num <= acc;
    end
    if (cmd.den_ld) begin
      den <= acc;
    end
    if (cmd.norm && den[ACCW-1]) begin
      den <= -den;
      num <= -num;
    end
    if (cmd.t_sel) begin
      dcnt <= '0;
      if (den == '0) begin
        t <= T_HALF;
      end else if (num[ACCW-1] || num == '0) begin
        t <= '0;
      end else if ($unsigned(num) >= $unsigned(den)) begin
        t <= T_ONE;
      end else begin
        t <= '0;
      end
    end
    if (cmd.div_step) begin
      dcnt <= dcnt + CNTW'(1);
      if (nshift >= $unsigned(den)) begin
        num <= $signed(nshift - $unsigned(den));
        t   <= {t[TW-2:0], 1'b1};
      end else begin
        num <= $signed(nshift);
        t   <= {t[TW-2:0], 1'b0};
      end
    end
    if (cmd.pt_x) begin
      if (clip_end) begin
        ex <= newc;
      end else begin
        sx <= newc;
      end
    end
    if (cmd.pt_y) begin
      if (clip_end) begin
        ey <= newc;
      end else begin
        sy <= newc;
      end
    end
    if (cmd.tidx_clr) begin
      tidx <= 2'd0;
    end
    if (cmd.mask_bit) begin
      tidx <= tidx + 2'd1;
      if (clip_end) begin
        me[tidx] <= ~acc[ACCW-1];
      end else begin
        ms[tidx] <= ~acc[ACCW-1];
      end
    end
    if (cmd.publish) begin
      clip_code    <= code;
      clip_start_x <= code[1] ? sx : '0;
      clip_start_y <= code[1] ? sy : '0;
      clip_end_x   <= code[0] ? ex : '0;
      clip_end_y   <= code[0] ? ey : '0;
    end
  end

  always_comb begin
    stat.cmd_border   = (cmd_r == pec_pkg::CMD_BORDER);
    stat.border_ok    = b_onehot && (b_all == ~bx_mask);
    stat.any_both_out = |(~ms & ~me);
    stat.cross_bit    = crossing[eidx];
    stat.both_out_bit = ~ms[eidx] & ~me[eidx];
    stat.diff_bit     = ms[eidx] ^ me[eidx];
    stat.code_both    = (code == pec_pkg::CODE_BOTH);
    stat.need_div     = (den != '0) && !num[ACCW-1] && (num != '0) &&
                        ($unsigned(num) < $unsigned(den));
    stat.div_last     = (dcnt == CNT_LAST);
    stat.tidx_last    = (tidx == 2'd3);
    stat.edge_last    = (eidx == 2'd3);
  end

endmodule
`default_nettype wire

FILE: src/pixel_edge_quad_clipper_top.sv
`default_nettype none
// Clips one edge segment against the convex quad held in the corner registers
// (Q16.16 by default, edge e runs from corner e to corner e+1). One item is worked
// at a time. A border clip finds the crossing on the one edge whose inside bits
// differ. An interior clip decodes the item, works through the four quad edges in
// turn, clipping those that the segment crosses and stepping past the others, and
// then publishes. A crossing whose parameter needs no division skips the divider,
// and items that clip nothing skip the crossing steps. The next input transfer
// comes at the earliest in the cycle after the result is written, and a result
// waits while the previous one is still held by a stalled output. The pace is set
// by the single shared multiplier and by the one-bit-per-cycle divider that finds
// the crossing parameter. A finished result is held in the output register while
// the next item is accepted. The user must write the corners only while idle; the
// block itself does not enforce it.
module pixel_edge_quad_clipper_top #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pec_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic signed [COORD_WIDTH-1:0]       cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                cmd,
  input  wire logic signed [COORD_WIDTH-1:0]       start_x,
  input  wire logic signed [COORD_WIDTH-1:0]       start_y,
  input  wire logic signed [COORD_WIDTH-1:0]       end_x,
  input  wire logic signed [COORD_WIDTH-1:0]       end_y,
  input  wire logic [3:0]                          start_inside,
  input  wire logic [3:0]                          end_inside,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               clip_code,
  output logic signed [COORD_WIDTH-1:0]            clip_start_x,
  output logic signed [COORD_WIDTH-1:0]            clip_start_y,
  output logic signed [COORD_WIDTH-1:0]            clip_end_x,
  output logic signed [COORD_WIDTH-1:0]            clip_end_y
);

  pec_pkg::ctl_cmd_t ctl;
  pec_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  pec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (ctl)
  );

  pec_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_cmd          (cmd),
    .in_start_x      (start_x),
    .in_start_y      (start_y),
    .in_end_x        (end_x),
    .in_end_y        (end_y),
    .in_start_inside (start_inside),
    .in_end_inside   (end_inside),
    .cmd             (ctl),
    .stat            (stat),
    .clip_code       (clip_code),
    .clip_start_x    (clip_start_x),
    .clip_start_y    (clip_start_y),
    .clip_end_x      (clip_end_x),
    .clip_end_y      (clip_end_y)
  );

endmodule
`default_nettype wire

FILE: sim/pixel_edge_quad_clipper_top_tb.sv
`default_nettype none
module pixel_edge_quad_clipper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam longint SQ = 64'sd100 <<< FB;
  localparam logic [FB:0] T_ONE  = {1'b1, {FB{1'b0}}};
  localparam logic [FB:0] T_HALF = {2'b01, {(FB-1){1'b0}}};

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic                 cmd;
    logic signed [CW-1:0] sx, sy, ex, ey;
    logic [3:0]           ms, me;
  } segment_t;

  typedef struct {
    logic [1:0]           code;
    logic signed [CW-1:0] csx, csy, cex, cey;
  } clip_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pec_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic signed [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = 1'b0;
  logic signed [CW-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic [3:0] start_inside = '0, end_inside = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] clip_code;
  logic signed [CW-1:0] clip_start_x, clip_start_y, clip_end_x, clip_end_y;

  pixel_edge_quad_clipper_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_top (.*);

  logic signed [CW-1:0] quad_x[4];
  logic signed [CW-1:0] quad_y[4];
  segment_t pending_segs[$];
  clip_t    expected_clips[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic in_fire = 1'b0;
  logic hold_off = 1'b0;
  logic hold_req = 1'b0;
  longint cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic wide_t wmul(longint a, longint b);
    wide_t wa, wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  function automatic longint qx(int e);
    return longint'(quad_x[e & 3]);
  endfunction

  function automatic longint qy(int e);
    return longint'(quad_y[e & 3]);
  endfunction

  function automatic logic [3:0] inside_bits(longint px, longint py);
    logic [3:0] m;
    longint bx, by;
    m = '0;
    for (int e = 0; e < 4; e++) begin
      bx = qx(e + 1) - qx(e);
      by = qy(e + 1) - qy(e);
      if (wmul(bx, py - qy(e)) - wmul(by, px - qx(e)) >= 0) m[e] = 1'b1;
    end
    return m;
  endfunction

  task automatic crossing_point(input longint ax0, input longint ay0, input longint ax1,
                                input longint ay1, input int e,
                                output longint ox, output longint oy);
    longint bx, by, dx, dy, basex, basey;
    wide_t num, den, px, py, q;
    logic [FB:0] t;
    logic signed [CW-1:0] rx, ry;
    bx = qx(e + 1) - qx(e);
    by = qy(e + 1) - qy(e);
    dx = ax1 - ax0;
    dy = ay1 - ay0;
    basex = ax0;
    basey = ay0;
    if (wmul(dx, bx) + wmul(dy, by) < 0) begin
      basex = ax1;
      basey = ay1;
      dx = -dx;
      dy = -dy;
    end
    num = -(wmul(basex - qx(e), by) - wmul(basey - qy(e), bx));
    den = wmul(dx, by) - wmul(dy, bx);
    if (den == 0) begin
      t = T_HALF;
    end else begin
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      if (num <= 0) t = '0;
      else if (num >= den) t = T_ONE;
      else begin
        q = (num <<< FB) / den;
        t = q[FB:0];
      end
    end
    px = wmul(dx, longint'(t)) >>> FB;
    py = wmul(dy, longint'(t)) >>> FB;
    rx = CW'(basex + px[63:0]);
    ry = CW'(basey + py[63:0]);
    ox = longint'(rx);
    oy = longint'(ry);
  endtask

  task automatic clip_segment(input segment_t s, output clip_t r);
    longint ax, ay, bx, by;
    logic [3:0] ms, me, x, crossing, b;
    logic [1:0] code;
    int e;
    ax = s.sx; ay = s.sy; bx = s.ex; by = s.ey;
    ms = s.ms; me = s.me;
    code = pec_pkg::CODE_NONE;
    if (s.cmd == pec_pkg::CMD_BORDER) begin
      x = ms ^ me;
      if (x != 0 && (x & (x - 4'd1)) == 0 && (ms & me) == ~x) begin
        e = 0;
        while (!x[e]) e++;
        if (|(ms & x)) begin
          code = pec_pkg::CODE_END;
          crossing_point(ax, ay, bx, by, e, bx, by);
        end else begin
          code = pec_pkg::CODE_START;
          crossing_point(ax, ay, bx, by, e, ax, ay);
        end
      end
    end else if ((~ms & ~me) == 4'h0) begin
      crossing = ms ^ me;
      for (e = 0; e < 4; e++) begin
        b = 4'(1 << e);
        if ((crossing & b) == 0) continue;
        if (code != pec_pkg::CODE_BOTH && (~ms & ~me & b) != 0) begin
          code = pec_pkg::CODE_NONE;
          break;
        end
        if (((ms ^ me) & b) != 0) begin
          if ((ms & b) != 0) begin
            crossing_point(ax, ay, bx, by, e, bx, by);
            me = inside_bits(bx, by);
            code = code | pec_pkg::CODE_END;
          end else begin
            crossing_point(ax, ay, bx, by, e, ax, ay);
            ms = inside_bits(ax, ay);
            code = code | pec_pkg::CODE_START;
          end
        end
      end
    end
    r.code = code;
    r.csx = code[1] ? CW'(ax) : '0;
    r.csy = code[1] ? CW'(ay) : '0;
    r.cex = code[0] ? CW'(bx) : '0;
    r.cey = code[0] ? CW'(by) : '0;
  endtask

  task automatic report(string field, logic [CW-1:0] want, logic [CW-1:0] got);
    $display("mismatch %s: expected %h got %h at %0t", field, want, got, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    clip_t r;
    segment_t s;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("pixel_edge_quad_clipper_top_tb: FAIL");
      $finish;
    end
    in_fire <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      s = '{cmd, start_x, start_y, end_x, end_y, start_inside, end_inside};
      clip_segment(s, r);
      expected_clips.push_back(r);
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_clips.size() == 0) begin
        report("unexpected transfer", '0, clip_code);
      end else begin
        r = expected_clips.pop_front();
        if (clip_code !== r.code) report("clip_code", r.code, clip_code);
        if (clip_start_x !== r.csx) report("clip_start_x", r.csx, clip_start_x);
        if (clip_start_y !== r.csy) report("clip_start_y", r.csy, clip_start_y);
        if (clip_end_x !== r.cex) report("clip_end_x", r.cex, clip_end_x);
        if (clip_end_y !== r.cey) report("clip_end_y", r.cey, clip_end_y);
      end
    end
  end

  always @(negedge clk) begin
    segment_t s;
    if (!in_valid || in_fire) begin
      if (!rst && pending_segs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s = pending_segs.pop_front();
        cmd <= s.cmd;
        start_x <= s.sx;
        start_y <= s.sy;
        end_x <= s.ex;
        end_y <= s.ey;
        start_inside <= s.ms;
        end_inside <= s.me;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic cfg_write(logic [pec_pkg::CFG_IDX_W-1:0] idx, logic signed [CW-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (idx <= pec_pkg::REG_C3Y) begin
      if (idx[0]) quad_y[idx[2:1]] = val;
      else quad_x[idx[2:1]] = val;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_quad(longint x0, longint y0, longint x1, longint y1,
                           longint x2, longint y2, longint x3, longint y3);
    cfg_write(pec_pkg::REG_C0X, CW'(x0));
    cfg_write(pec_pkg::REG_C0Y, CW'(y0));
    cfg_write(pec_pkg::REG_C1X, CW'(x1));
    cfg_write(pec_pkg::REG_C1Y, CW'(y1));
    cfg_write(pec_pkg::REG_C2X, CW'(x2));
    cfg_write(pec_pkg::REG_C2Y, CW'(y2));
    cfg_write(pec_pkg::REG_C3X, CW'(x3));
    cfg_write(pec_pkg::REG_C3Y, CW'(y3));
  endtask

  task automatic add_raw(logic c, longint x0, longint y0, longint x1, longint y1,
                         logic [3:0] ms, logic [3:0] me);
    segment_t s;
    s.cmd = c;
    s.sx = CW'(x0); s.sy = CW'(y0); s.ex = CW'(x1); s.ey = CW'(y1);
    s.ms = ms; s.me = me;
    pending_segs.push_back(s);
  endtask

  task automatic add_seg(logic c, longint x0, longint y0, longint x1, longint y1);
    logic signed [CW-1:0] a, b, d, f;
    a = CW'(x0); b = CW'(y0); d = CW'(x1); f = CW'(y1);
    add_raw(c, a, b, d, f, inside_bits(a, b), inside_bits(d, f));
  endtask

  function automatic longint rand_coord(longint span);
    if (span >= (64'sd1 <<< 31) || $urandom_range(0, 9) == 0)
      return longint'($signed($urandom()));
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  task automatic add_random(int n, longint span);
    logic c;
    longint x0, y0, x1, y1;
    for (int i = 0; i < n; i++) begin
      c = 1'($urandom_range(0, 1));
      x0 = rand_coord(span); y0 = rand_coord(span);
      x1 = rand_coord(span); y1 = rand_coord(span);
      if ($urandom_range(0, 99) < 85) add_seg(c, x0, y0, x1, y1);
      else add_raw(c, x0, y0, x1, y1, 4'($urandom), 4'($urandom));
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_segs.size() != 0 || in_valid || expected_clips.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle(int src, int dst);
    send_idle_pct = src;
    recv_stall_pct = dst;
  endtask

  initial begin
    longint x0, x1, y0, y1;
    for (int k = 0; k < 4; k++) begin
      quad_x[k] = '0;
      quad_y[k] = '0;
    end
    repeat (4) @(negedge clk);
    rst = 1'b0;

    set_idle(0, 0);
    add_random(20, SQ);
    drain();

    load_quad(-SQ, -SQ, SQ, -SQ, SQ, SQ, -SQ, SQ);
    add_seg(pec_pkg::CMD_INTERIOR, 0, 0, SQ / 2, SQ / 2);
    add_seg(pec_pkg::CMD_INTERIOR, 0, -2 * SQ, SQ / 2, -2 * SQ);
    add_seg(pec_pkg::CMD_INTERIOR, 0, 0, 2 * SQ, 0);
    add_seg(pec_pkg::CMD_INTERIOR, -2 * SQ, 0, 0, 0);
    add_seg(pec_pkg::CMD_INTERIOR, -2 * SQ, 0, 2 * SQ, SQ / 2);
    add_seg(pec_pkg::CMD_INTERIOR, -2 * SQ, -2 * SQ, 2 * SQ, 2 * SQ);
    add_seg(pec_pkg::CMD_INTERIOR, 2 * SQ, 0, 0, 2 * SQ);
    add_seg(pec_pkg::CMD_INTERIOR, 0, 3 * SQ, 3 * SQ, SQ / 2);
    add_raw(pec_pkg::CMD_INTERIOR, 0, -2 * SQ, SQ, -2 * SQ, 4'hF, 4'hE);
    add_raw(pec_pkg::CMD_INTERIOR, 0, 0, 0, 0, 4'hF, 4'hE);
    add_seg(pec_pkg::CMD_BORDER, 0, 0, 0, -2 * SQ);
    add_seg(pec_pkg::CMD_BORDER, 0, 2 * SQ, 0, 0);
    add_seg(pec_pkg::CMD_BORDER, 2 * SQ, 2 * SQ, 0, 0);
    add_seg(pec_pkg::CMD_BORDER, 0, 0, 1, 1);
    add_raw(pec_pkg::CMD_BORDER, SQ, SQ, -SQ, 3 * SQ, 4'h7, 4'hF);
    add_raw(pec_pkg::CMD_BORDER, 0, 0, SQ, SQ, 4'h0, 4'h0);
    add_raw(pec_pkg::CMD_BORDER, 0, 0, SQ, SQ, 4'hE, 4'hC);
    add_seg(pec_pkg::CMD_INTERIOR, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
            64'sd2147483647);
    add_seg(pec_pkg::CMD_BORDER, -64'sd2147483648, 0, 0, 0);
    add_raw(pec_pkg::CMD_INTERIOR, 64'sd2147483647, -64'sd2147483648, -64'sd2147483648,
            64'sd2147483647, 4'hF, 4'h0);
    add_raw(pec_pkg::CMD_INTERIOR, 64'sd2147483647, 64'sd2147483647, -64'sd2147483648,
            -64'sd2147483648, 4'h0, 4'hF);
    add_random(110, 3 * SQ);
    drain();

    load_quad(0, -(64'sd1 <<< 30), 64'sd1 <<< 30, 0, 0, 64'sd1 <<< 30,
              -(64'sd1 <<< 30), 0);
    cfg_write(4'(pec_pkg::REG_C3Y + 1 + $urandom_range(0, 7)), $urandom());
    set_idle(46, 0);
    add_random(130, 64'sd1 <<< 31);
    drain();

    x0 = -longint'($urandom_range(1, 1 << 24)); x1 = longint'($urandom_range(1, 1 << 24));
    y0 = -longint'($urandom_range(1, 1 << 24)); y1 = longint'($urandom_range(1, 1 << 24));
    load_quad(x0, y0, x1, y0, x1, y1, x0, y1);
    set_idle(0, 46);
    add_random(130, 64'sd1 <<< 25);
    hold_req = 1'b1;
    drain();

    load_quad(-SQ, -SQ, SQ, -SQ, SQ, -SQ, -SQ, SQ);
    set_idle(38, 38);
    add_random(120, 3 * SQ);
    drain();

    load_quad(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
              64'sd2147483647, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647);
    set_idle(38, 38);
    add_random(120, 64'sd1 <<< 31);
    drain();

    if (errors == 0) begin
      $display("pixel_edge_quad_clipper_top_tb: PASS");
    end else begin
      $display("pixel_edge_quad_clipper_top_tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: pixel_edge_quad_clipper_top.f
src/pec_pkg.sv
src/pec_ctrl.sv
src/pec_dp.sv
src/pixel_edge_quad_clipper_top.sv
sim/pixel_edge_quad_clipper_top_tb.sv
